### sv/vna_pkg.sv
// ----------------------------------------------------------------------------
// vna_pkg
// shared types and defaults for the vertex normal accumulator
// ----------------------------------------------------------------------------
package vna_pkg;

    localparam int VERTEX_COUNT_DEF = 4096;
    localparam int COORD_WIDTH_DEF  = 16;
    localparam int ACC_WIDTH_DEF    = 48;

    // fixed port widths of one item
    localparam int IDX_WIDTH        = 12;
    localparam int COORD_PORT_WIDTH = 16;
    localparam int KIND_WIDTH       = 2;

    typedef enum logic [KIND_WIDTH-1:0] {
        KIND_LOAD = 2'd0,
        KIND_TRI  = 2'd1,
        KIND_READ = 2'd2
    } kind_t;

    // triangle corner select
    typedef enum logic [1:0] {
        SEL_A = 2'd0,
        SEL_B = 2'd1,
        SEL_C = 2'd2
    } sel_t;

    // cross product component select
    typedef enum logic [1:0] {
        COMP_X = 2'd0,
        COMP_Y = 2'd1,
        COMP_Z = 2'd2
    } comp_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_LOAD,
        S_RD_A,
        S_RD_B,
        S_RD_C,
        S_DIFF,
        S_MUL_X,
        S_MUL_Y,
        S_MUL_Z,
        S_SUB_Z,
        S_ACC_RD,
        S_ACC_WR,
        S_NRM_RD,
        S_NRM_OUT
    } state_t;

    typedef struct packed {
        logic  item_load;
        logic  vtx_wr;
        logic  vtx_rd;
        sel_t  vtx_sel;
        logic  vtx_shift;
        logic  diff_en;
        logic  mul_en;
        comp_t mul_sel;
        logic  sub_en;
        comp_t sub_sel;
        logic  nrm_rd;
        sel_t  nrm_sel;
        logic  acc_wr;
        logic  rd_out;
        logic  clr_wr;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  a_ok;
        logic  tri_ok;
        logic  clr_last;
    } status_t;

endpackage

### sv/vna_ctrl.sv
// ----------------------------------------------------------------------------
// vna_ctrl
// sequencer for the clearing pass and for load, triangle and read beats
// ----------------------------------------------------------------------------
module vna_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output vna_pkg::cmd_t     cmd,
    input  vna_pkg::status_t  status
);

    vna_pkg::state_t state_reg;
    vna_pkg::state_t state_next;
    vna_pkg::sel_t   corner_reg;
    vna_pkg::sel_t   corner_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= vna_pkg::S_CLEAR;
            corner_reg <= vna_pkg::SEL_A;
        end
        else
        begin
            state_reg  <= state_next;
            corner_reg <= corner_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        corner_next = corner_reg;
        cmd         = '0;
        case (state_reg)
            vna_pkg::S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (status.clr_last)
                    state_next = vna_pkg::S_IDLE;
            end
            vna_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.item_load = 1'b1;
                    state_next    = vna_pkg::S_DECODE;
                end
            end
            vna_pkg::S_DECODE:
            begin
                case (status.kind)
                    vna_pkg::KIND_LOAD:
                        state_next = status.a_ok ? vna_pkg::S_LOAD : vna_pkg::S_IDLE;
                    vna_pkg::KIND_TRI:
                        state_next = status.tri_ok ? vna_pkg::S_RD_A : vna_pkg::S_IDLE;
                    vna_pkg::KIND_READ:
                        state_next = vna_pkg::S_NRM_RD;
                    default:
                        state_next = vna_pkg::S_IDLE;
                endcase
            end
            vna_pkg::S_LOAD:
            begin
                cmd.vtx_wr = 1'b1;
                state_next = vna_pkg::S_IDLE;
            end
            vna_pkg::S_RD_A:
            begin
                cmd.vtx_rd  = 1'b1;
                cmd.vtx_sel = vna_pkg::SEL_A;
                state_next  = vna_pkg::S_RD_B;
            end
            vna_pkg::S_RD_B:
            begin
                cmd.vtx_rd    = 1'b1;
                cmd.vtx_sel   = vna_pkg::SEL_B;
                cmd.vtx_shift = 1'b1;
                state_next    = vna_pkg::S_RD_C;
            end
            vna_pkg::S_RD_C:
            begin
                cmd.vtx_rd    = 1'b1;
                cmd.vtx_sel   = vna_pkg::SEL_C;
                cmd.vtx_shift = 1'b1;
                state_next    = vna_pkg::S_DIFF;
            end
            vna_pkg::S_DIFF:
            begin
                cmd.diff_en = 1'b1;
                state_next  = vna_pkg::S_MUL_X;
            end
            vna_pkg::S_MUL_X:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = vna_pkg::COMP_X;
                state_next  = vna_pkg::S_MUL_Y;
            end
            vna_pkg::S_MUL_Y:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = vna_pkg::COMP_Y;
                cmd.sub_en  = 1'b1;
                cmd.sub_sel = vna_pkg::COMP_X;
                state_next  = vna_pkg::S_MUL_Z;
            end
            vna_pkg::S_MUL_Z:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = vna_pkg::COMP_Z;
                cmd.sub_en  = 1'b1;
                cmd.sub_sel = vna_pkg::COMP_Y;
                state_next  = vna_pkg::S_SUB_Z;
            end
            vna_pkg::S_SUB_Z:
            begin
                cmd.sub_en  = 1'b1;
                cmd.sub_sel = vna_pkg::COMP_Z;
                corner_next = vna_pkg::SEL_A;
                state_next  = vna_pkg::S_ACC_RD;
            end
            vna_pkg::S_ACC_RD:
            begin
                cmd.nrm_rd  = 1'b1;
                cmd.nrm_sel = corner_reg;
                state_next  = vna_pkg::S_ACC_WR;
            end
            vna_pkg::S_ACC_WR:
            begin
                cmd.acc_wr  = 1'b1;
                cmd.nrm_sel = corner_reg;
                case (corner_reg)
                    vna_pkg::SEL_A:
                    begin
                        corner_next = vna_pkg::SEL_B;
                        state_next  = vna_pkg::S_ACC_RD;
                    end
                    vna_pkg::SEL_B:
                    begin
                        corner_next = vna_pkg::SEL_C;
                        state_next  = vna_pkg::S_ACC_RD;
                    end
                    default:
                        state_next = vna_pkg::S_IDLE;
                endcase
            end
            vna_pkg::S_NRM_RD:
            begin
                cmd.nrm_rd  = 1'b1;
                cmd.nrm_sel = vna_pkg::SEL_A;
                state_next  = vna_pkg::S_NRM_OUT;
            end
            vna_pkg::S_NRM_OUT:
            begin
                cmd.rd_out = 1'b1;
                state_next = vna_pkg::S_IDLE;
            end
            default:
                state_next = vna_pkg::S_IDLE;
        endcase
    end

    assign busy = (state_reg != vna_pkg::S_IDLE);

endmodule

### sv/vna_datapath.sv
// ----------------------------------------------------------------------------
// vna_datapath
// vertex and normal stores, cross product and saturating accumulate
// ----------------------------------------------------------------------------
module vna_datapath #(
    parameter int VERTEX_COUNT = vna_pkg::VERTEX_COUNT_DEF,
    parameter int COORD_WIDTH  = vna_pkg::COORD_WIDTH_DEF,
    parameter int ACC_WIDTH    = vna_pkg::ACC_WIDTH_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  vna_pkg::cmd_t                                 cmd,
    output vna_pkg::status_t                              status,
    input  logic [vna_pkg::KIND_WIDTH-1:0]                kind,
    input  logic [vna_pkg::IDX_WIDTH-1:0]                 vert_a,
    input  logic [vna_pkg::IDX_WIDTH-1:0]                 vert_b,
    input  logic [vna_pkg::IDX_WIDTH-1:0]                 vert_c,
    input  logic signed [vna_pkg::COORD_PORT_WIDTH-1:0]   coord_x,
    input  logic signed [vna_pkg::COORD_PORT_WIDTH-1:0]   coord_y,
    input  logic signed [vna_pkg::COORD_PORT_WIDTH-1:0]   coord_z,
    output logic                                          done,
    output logic signed [ACC_WIDTH-1:0]                   normal_x,
    output logic signed [ACC_WIDTH-1:0]                   normal_y,
    output logic signed [ACC_WIDTH-1:0]                   normal_z,
    output logic                                          saturated
);

    localparam int AW = $clog2(VERTEX_COUNT);
    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int NW = PW + 1;
    localparam int SW = ((ACC_WIDTH > NW) ? ACC_WIDTH : NW) + 1;
    localparam int VW = 3 * CW;
    localparam int EW = 3 * ACC_WIDTH + 1;

    localparam logic signed [SW-1:0] ACC_HI =
        {{(SW - ACC_WIDTH + 1){1'b0}}, {(ACC_WIDTH - 1){1'b1}}};
    localparam logic signed [SW-1:0] ACC_LO = ~ACC_HI;

    // latched item
    vna_pkg::kind_t                  kind_reg;
    logic [vna_pkg::IDX_WIDTH-1:0]   a_reg;
    logic [vna_pkg::IDX_WIDTH-1:0]   b_reg;
    logic [vna_pkg::IDX_WIDTH-1:0]   c_reg;
    logic [CW-1:0]                   ld_x_reg;
    logic [CW-1:0]                   ld_y_reg;
    logic [CW-1:0]                   ld_z_reg;

    logic          a_ok;
    logic          b_ok;
    logic          c_ok;
    logic [AW-1:0] a_addr;
    logic [AW-1:0] b_addr;
    logic [AW-1:0] c_addr;

    // vertex store
    logic [VW-1:0] vtx_mem [VERTEX_COUNT];
    logic [VW-1:0] vtx_q_reg;
    logic [AW-1:0] vtx_raddr;
    logic [VW-1:0] pos_a_reg;
    logic [VW-1:0] pos_b_reg;

    logic signed [CW-1:0] pa_x, pa_y, pa_z;
    logic signed [CW-1:0] pb_x, pb_y, pb_z;
    logic signed [CW-1:0] pc_x, pc_y, pc_z;

    logic signed [DW-1:0] ux_reg, uy_reg, uz_reg;
    logic signed [DW-1:0] wx_reg, wy_reg, wz_reg;
    logic signed [DW-1:0] m1a, m1b, m2a, m2b;
    logic signed [PW-1:0] prod1_reg;
    logic signed [PW-1:0] prod2_reg;
    logic signed [NW-1:0] cross_diff;
    logic signed [NW-1:0] n_x_reg, n_y_reg, n_z_reg;

    // normal store, entry is {flag, z, y, x}
    logic [EW-1:0] nrm_mem [VERTEX_COUNT];
    logic [EW-1:0] nrm_q_reg;
    logic [AW-1:0] nrm_raddr;
    logic          nrm_we;
    logic [AW-1:0] nrm_waddr;
    logic [EW-1:0] nrm_wdata;

    logic signed [ACC_WIDTH-1:0] acc_x, acc_y, acc_z;
    logic                        acc_flag;
    logic [ACC_WIDTH:0]          sum_x, sum_y, sum_z;
    logic [EW-1:0]               acc_entry;

    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] clr_cnt_next;

    logic                        done_reg;
    logic signed [ACC_WIDTH-1:0] normal_x_reg;
    logic signed [ACC_WIDTH-1:0] normal_y_reg;
    logic signed [ACC_WIDTH-1:0] normal_z_reg;
    logic                        saturated_reg;

    // returns {clamped, value}
    function automatic logic [ACC_WIDTH:0] sat_add(
        input logic signed [ACC_WIDTH-1:0] acc,
        input logic signed [NW-1:0]        v
    );
        logic signed [SW-1:0] sum;
        sum = SW'(acc) + SW'(v);
        if (sum > ACC_HI)
            sat_add = {1'b1, ACC_HI[ACC_WIDTH-1:0]};
        else if (sum < ACC_LO)
            sat_add = {1'b1, ACC_LO[ACC_WIDTH-1:0]};
        else
            sat_add = {1'b0, sum[ACC_WIDTH-1:0]};
    endfunction

    function automatic logic [AW-1:0] corner_addr(
        input vna_pkg::sel_t sel,
        input logic [AW-1:0] aa,
        input logic [AW-1:0] ba,
        input logic [AW-1:0] ca
    );
        case (sel)
            vna_pkg::SEL_A: corner_addr = aa;
            vna_pkg::SEL_B: corner_addr = ba;
            vna_pkg::SEL_C: corner_addr = ca;
            default:        corner_addr = aa;
        endcase
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            kind_reg <= vna_pkg::kind_t'(kind);
            a_reg    <= vert_a;
            b_reg    <= vert_b;
            c_reg    <= vert_c;
            // keep the low coordinate bits, zero fill above the port
            ld_x_reg <= CW'($unsigned(coord_x));
            ld_y_reg <= CW'($unsigned(coord_y));
            ld_z_reg <= CW'($unsigned(coord_z));
        end
    end

    assign a_ok   = (32'(a_reg) < VERTEX_COUNT);
    assign b_ok   = (32'(b_reg) < VERTEX_COUNT);
    assign c_ok   = (32'(c_reg) < VERTEX_COUNT);
    assign a_addr = AW'(a_reg);
    assign b_addr = AW'(b_reg);
    assign c_addr = AW'(c_reg);

    assign status.kind     = kind_reg;
    assign status.a_ok     = a_ok;
    assign status.tri_ok   = a_ok && b_ok && c_ok;
    assign status.clr_last = (clr_cnt_reg == AW'(VERTEX_COUNT - 1));

    // vertex store port
    assign vtx_raddr = corner_addr(cmd.vtx_sel, a_addr, b_addr, c_addr);

    always_ff @(posedge clk)
    begin
        if (cmd.vtx_wr)
            vtx_mem[a_addr] <= {ld_z_reg, ld_y_reg, ld_x_reg};
        if (cmd.vtx_rd)
            vtx_q_reg <= vtx_mem[vtx_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.vtx_shift)
        begin
            pos_a_reg <= pos_b_reg;
            pos_b_reg <= vtx_q_reg;
        end
    end

    assign pa_x = pos_a_reg[CW-1:0];
    assign pa_y = pos_a_reg[2*CW-1:CW];
    assign pa_z = pos_a_reg[3*CW-1:2*CW];
    assign pb_x = pos_b_reg[CW-1:0];
    assign pb_y = pos_b_reg[2*CW-1:CW];
    assign pb_z = pos_b_reg[3*CW-1:2*CW];
    assign pc_x = vtx_q_reg[CW-1:0];
    assign pc_y = vtx_q_reg[2*CW-1:CW];
    assign pc_z = vtx_q_reg[3*CW-1:2*CW];

    // edges u = c - b, w = a - b
    always_ff @(posedge clk)
    begin
        if (cmd.diff_en)
        begin
            ux_reg <= DW'(pc_x) - DW'(pb_x);
            uy_reg <= DW'(pc_y) - DW'(pb_y);
            uz_reg <= DW'(pc_z) - DW'(pb_z);
            wx_reg <= DW'(pa_x) - DW'(pb_x);
            wy_reg <= DW'(pa_y) - DW'(pb_y);
            wz_reg <= DW'(pa_z) - DW'(pb_z);
        end
    end

    // operand pairs for one cross component
    always_comb
    begin
        case (cmd.mul_sel)
            vna_pkg::COMP_X:
            begin
                m1a = uy_reg; m1b = wz_reg; m2a = uz_reg; m2b = wy_reg;
            end
            vna_pkg::COMP_Y:
            begin
                m1a = uz_reg; m1b = wx_reg; m2a = ux_reg; m2b = wz_reg;
            end
            vna_pkg::COMP_Z:
            begin
                m1a = ux_reg; m1b = wy_reg; m2a = uy_reg; m2b = wx_reg;
            end
            default:
            begin
                m1a = uy_reg; m1b = wz_reg; m2a = uz_reg; m2b = wy_reg;
            end
        endcase
    end

    assign cross_diff = NW'(prod1_reg) - NW'(prod2_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod1_reg <= PW'(m1a) * PW'(m1b);
            prod2_reg <= PW'(m2a) * PW'(m2b);
        end
        if (cmd.sub_en)
        begin
            case (cmd.sub_sel)
                vna_pkg::COMP_X: n_x_reg <= cross_diff;
                vna_pkg::COMP_Y: n_y_reg <= cross_diff;
                vna_pkg::COMP_Z: n_z_reg <= cross_diff;
                default:         n_x_reg <= cross_diff;
            endcase
        end
    end

    // read-modify-write of one normal entry
    assign acc_x    = nrm_q_reg[ACC_WIDTH-1:0];
    assign acc_y    = nrm_q_reg[2*ACC_WIDTH-1:ACC_WIDTH];
    assign acc_z    = nrm_q_reg[3*ACC_WIDTH-1:2*ACC_WIDTH];
    assign acc_flag = nrm_q_reg[EW-1];

    assign sum_x = sat_add(acc_x, n_x_reg);
    assign sum_y = sat_add(acc_y, n_y_reg);
    assign sum_z = sat_add(acc_z, n_z_reg);

    assign acc_entry = {acc_flag | sum_x[ACC_WIDTH] | sum_y[ACC_WIDTH] | sum_z[ACC_WIDTH],
                        sum_z[ACC_WIDTH-1:0], sum_y[ACC_WIDTH-1:0], sum_x[ACC_WIDTH-1:0]};

    assign nrm_raddr = corner_addr(cmd.nrm_sel, a_addr, b_addr, c_addr);

    always_comb
    begin
        nrm_we    = 1'b0;
        nrm_waddr = a_addr;
        nrm_wdata = '0;
        if (cmd.clr_wr)
        begin
            nrm_we    = 1'b1;
            nrm_waddr = clr_cnt_reg;
        end
        else if (cmd.acc_wr)
        begin
            nrm_we    = 1'b1;
            nrm_waddr = nrm_raddr;
            nrm_wdata = acc_entry;
        end
        else if (cmd.rd_out)
        begin
            nrm_we = a_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (nrm_we)
            nrm_mem[nrm_waddr] <= nrm_wdata;
        if (cmd.nrm_rd)
            nrm_q_reg <= nrm_mem[nrm_raddr];
    end

    assign clr_cnt_next = clr_cnt_reg + AW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clr_wr)
                clr_cnt_reg <= clr_cnt_next;
            done_reg <= cmd.rd_out;
        end
    end

    // out of range read gives zeros
    always_ff @(posedge clk)
    begin
        if (cmd.rd_out)
        begin
            normal_x_reg  <= a_ok ? acc_x : '0;
            normal_y_reg  <= a_ok ? acc_y : '0;
            normal_z_reg  <= a_ok ? acc_z : '0;
            saturated_reg <= a_ok & acc_flag;
        end
    end

    assign done      = done_reg;
    assign normal_x  = normal_x_reg;
    assign normal_y  = normal_y_reg;
    assign normal_z  = normal_z_reg;
    assign saturated = saturated_reg;

endmodule

### sv/vertex_normal_accumulator.sv
// ----------------------------------------------------------------------------
// vertex_normal_accumulator
// area weighted vertex normal accumulation over a triangle mesh
// ----------------------------------------------------------------------------
// read path: a read beat is taken in idle, then passes decode, the normal
//   store read and the output step, which registers done and the result
// sequence: the sequencer walks three vertex reads, a shared two-multiplier
//   cross product and a read-modify-write of each corner on one normal store
//   port; a new item is taken only while busy is low
// reset: asynchronous, active low; then a clearing pass zeroes every entry
//   of the normal store while busy is high
// the receiver cannot stall: done is high for one cycle only
// ----------------------------------------------------------------------------
module vertex_normal_accumulator #(
    parameter int VERTEX_COUNT = vna_pkg::VERTEX_COUNT_DEF,
    parameter int COORD_WIDTH  = vna_pkg::COORD_WIDTH_DEF,
    parameter int ACC_WIDTH    = vna_pkg::ACC_WIDTH_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    // command side
    input  logic                                          start,
    output logic                                          busy,
    input  logic [vna_pkg::KIND_WIDTH-1:0]                kind,
    input  logic [vna_pkg::IDX_WIDTH-1:0]                 vert_a,
    input  logic [vna_pkg::IDX_WIDTH-1:0]                 vert_b,
    input  logic [vna_pkg::IDX_WIDTH-1:0]                 vert_c,
    input  logic signed [vna_pkg::COORD_PORT_WIDTH-1:0]   coord_x,
    input  logic signed [vna_pkg::COORD_PORT_WIDTH-1:0]   coord_y,
    input  logic signed [vna_pkg::COORD_PORT_WIDTH-1:0]   coord_z,
    // result side, one beat per read item
    output logic                                          done,
    output logic signed [ACC_WIDTH-1:0]                   normal_x,
    output logic signed [ACC_WIDTH-1:0]                   normal_y,
    output logic signed [ACC_WIDTH-1:0]                   normal_z,
    output logic                                          saturated
);

    // command and status between sequencer and datapath
    vna_pkg::cmd_t    cmd;
    vna_pkg::status_t status;

    // sequencer: clearing pass, decode, and the per-kind step sequence
    vna_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    // datapath: item latch, vertex store, edge vectors, cross product,
    // saturating add into the normal store, result registers
    vna_datapath #(
        .VERTEX_COUNT (VERTEX_COUNT),
        .COORD_WIDTH  (COORD_WIDTH),
        .ACC_WIDTH    (ACC_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .kind      (kind),
        .vert_a    (vert_a),
        .vert_b    (vert_b),
        .vert_c    (vert_c),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .coord_z   (coord_z),
        .done      (done),
        .normal_x  (normal_x),
        .normal_y  (normal_y),
        .normal_z  (normal_z),
        .saturated (saturated)
    );

endmodule

### sv/vna_checker.sv
// ----------------------------------------------------------------------------
// vna_checker
// port level checks on the command and result beats
// ----------------------------------------------------------------------------
module vna_checker #(
    parameter int VERTEX_COUNT = vna_pkg::VERTEX_COUNT_DEF,
    parameter int ACC_WIDTH    = vna_pkg::ACC_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic                                   busy,
    input  logic [vna_pkg::KIND_WIDTH-1:0]         kind,
    input  logic [vna_pkg::IDX_WIDTH-1:0]          vert_a,
    input  logic                                   done,
    input  logic signed [ACC_WIDTH-1:0]            normal_x,
    input  logic signed [ACC_WIDTH-1:0]            normal_y,
    input  logic signed [ACC_WIDTH-1:0]            normal_z,
    input  logic                                   saturated
);

    logic accept;
    logic read_beat;
    logic read_out_of_range;

    assign accept            = start && !busy;
    assign read_beat         = accept && (kind == vna_pkg::KIND_READ);
    assign read_out_of_range = read_beat && (32'(vert_a) >= VERTEX_COUNT);

    // result strobe lasts one cycle
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held longer than one cycle");

    // a read beat gives its result
    assert property (@(posedge clk) disable iff (!rst_n) read_beat |-> ##4 done)
        else $error("read beat without result");

    // load, triangle and ignored beats give no result
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind != vna_pkg::KIND_READ)) |-> ##4 !done)
        else $error("result from a non-read beat");

    // read of an index beyond the store returns all zero
    assert property (@(posedge clk) disable iff (!rst_n)
        read_out_of_range |-> ##4 (normal_x == '0 && normal_y == '0 &&
                                   normal_z == '0 && !saturated))
        else $error("out of range read not zero");

endmodule

bind vertex_normal_accumulator vna_checker #(
    .VERTEX_COUNT (VERTEX_COUNT),
    .ACC_WIDTH    (ACC_WIDTH)
) u_vna_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .kind      (kind),
    .vert_a    (vert_a),
    .done      (done),
    .normal_x  (normal_x),
    .normal_y  (normal_y),
    .normal_z  (normal_z),
    .saturated (saturated)
);
